// ===== design/pewg_pkg.sv =====
// Shared types, constants and saturating helpers for the polynomial evaluator.
package pewg_pkg;

  localparam int unsigned ORDER_DEFAULT = 3;
  localparam int unsigned ORDER_MIN     = 1;
  localparam int unsigned ORDER_MAX     = 3;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WIDE_W     = 64;
  localparam int unsigned TERM_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned OUT_DATA_W = 3 * WORD_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_3 = 3'd3;

  localparam logic signed [WIDE_W-1:0] Q_ONE      = 64'sd65536;
  localparam logic signed [WIDE_W-1:0] Q_NEG_HALF = -64'sd32768;
  localparam logic signed [WIDE_W-1:0] SAT_POS    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [WIDE_W-1:0] SAT_NEG    = 64'sh8000_0000_0000_0001;
  localparam logic signed [WIDE_W:0]   SUM_POS    = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [WIDE_W:0]   SUM_NEG    = 65'sh1_8000_0000_0000_0001;
  localparam logic signed [WIDE_W-1:0] W32_MAX    = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] W32_MIN    = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [2:0] {A_D, A_P, A_DP, A_M, A_PW} a_sel_e;
  typedef enum logic [1:0] {B_D, B_M, B_HALF} b_sel_e;
  typedef enum logic [1:0] {C_ZERO, C_COEFF, C_SLOPE} c_sel_e;
  typedef enum logic [2:0] {DST_P, DST_DP, DST_M, DST_S, DST_PW} dst_e;

  typedef struct packed {
    logic              load_in;
    logic              start_op;
    a_sel_e            a_sel;
    b_sel_e            b_sel;
    c_sel_e            c_sel;
    logic [TERM_W-1:0] idx;
    dst_e              dst;
    logic              load_out;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
  } status_t;

  function automatic int unsigned clamp_order(input int unsigned order);
    int unsigned r;
    r = order;
    if (r < ORDER_MIN) r = ORDER_MIN;
    if (r > ORDER_MAX) r = ORDER_MAX;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [WORD_W-1:0] r;
    if (v > W32_MAX) r = 32'h7FFF_FFFF;
    else if (v < W32_MIN) r = 32'h8000_0000;
    else r = v[WORD_W-1:0];
    return r;
  endfunction

  function automatic logic signed [WIDE_W-1:0] sadd(input logic signed [WIDE_W-1:0] a,
                                                    input logic signed [WIDE_W-1:0] b);
    logic signed [WIDE_W:0]   sum;
    logic signed [WIDE_W-1:0] r;
    sum = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
    if (sum > SUM_POS) r = SAT_POS;
    else if (sum < SUM_NEG) r = SAT_NEG;
    else r = sum[WIDE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [WIDE_W-1:0] sext32(input logic [WORD_W-1:0] v);
    return {{(WIDE_W-WORD_W){v[WORD_W-1]}}, v};
  endfunction

endpackage

// ===== design/polynomial_eval_with_gradients.sv =====
// Evaluates p(d) = c0 + c1 d + c2 d^2 + c3 d^3 (up to POLY_ORDER) in Q16.16 for each input beat
// and returns POLY_ORDER+1 output beats, one per power d^k, each carrying p(d) and
// p'(d) * (-0.5 d^3). All products run on one shared 32x32 multiplier that builds each
// 64x64 Q16.16 product from four partial products, then rounds, saturates and adds the
// coefficient. An item needs 3*POLY_ORDER+3 products. One item is worked on at a time;
// the next is taken as soon as its last beat sits in the output register.
// Coefficients reset to zero. The user must write them only while the block is idle;
// the block itself does not enforce this.
module polynomial_eval_with_gradients #(
  parameter int unsigned POLY_ORDER = pewg_pkg::ORDER_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pewg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pewg_pkg::WORD_W-1:0]         cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pewg_pkg::WORD_W-1:0]         s_axis_tdata,   // [31:0] width_in
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] poly_value, [63:32] inv_dsq_slope, [95:64] width_power
  output logic [pewg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [pewg_pkg::TERM_W-1:0]         m_axis_tuser,   // [1:0] term_index
  output logic                                m_axis_tlast
);

  pewg_pkg::cmd_t    cmd;
  pewg_pkg::status_t status;

  pewg_ctrl #(
    .POLY_ORDER (POLY_ORDER)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pewg_datapath #(
    .POLY_ORDER (POLY_ORDER)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== design/pewg_qmul.sv =====
// Iterative Q16.16 multiplier: one 32x32 partial product per cycle, rounded and saturated.
module pewg_qmul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pewg_pkg::WIDE_W-1:0]  a_i,
  input  logic signed [pewg_pkg::WIDE_W-1:0]  b_i,
  output logic                                done_o,
  output logic signed [pewg_pkg::WIDE_W-1:0]  res_o
);

  localparam int unsigned HW    = pewg_pkg::WIDE_W / 2;
  localparam int unsigned ACC_W = 2 * pewg_pkg::WIDE_W;

  logic                                mul_run_q, acc_run_q, rnd_q, done_q;
  logic [1:0]                          mstep_q;
  logic [pewg_pkg::WIDE_W-1:0]         am_q, bm_q, prod_q;
  logic [1:0]                          pshift_q;
  logic [ACC_W-1:0]                    acc_q, shifted, rounded;
  logic                                neg_q;
  logic signed [pewg_pkg::WIDE_W-1:0]  res_q;
  logic [HW-1:0]                       a_half, b_half;
  logic [pewg_pkg::WIDE_W-1:0]         prod_d;
  logic [pewg_pkg::WIDE_W-2:0]         mag;
  logic signed [pewg_pkg::WIDE_W-1:0]  mag_s;

  assign a_half  = mstep_q[0] ? am_q[pewg_pkg::WIDE_W-1:HW] : am_q[HW-1:0];
  assign b_half  = mstep_q[1] ? bm_q[pewg_pkg::WIDE_W-1:HW] : bm_q[HW-1:0];
  assign prod_d  = a_half * b_half;
  assign shifted = {{(ACC_W-pewg_pkg::WIDE_W){1'b0}}, prod_q} << {pshift_q, 5'd0};
  assign rounded = acc_q + ACC_W'(32768);
  assign mag     = rounded[pewg_pkg::WIDE_W+14:16];
  assign mag_s   = {1'b0, mag};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_run_q <= 1'b0;
      acc_run_q <= 1'b0;
      rnd_q     <= 1'b0;
      done_q    <= 1'b0;
      mstep_q   <= '0;
    end else begin
      acc_run_q <= mul_run_q;
      rnd_q     <= acc_run_q && !mul_run_q;
      done_q    <= rnd_q;
      if (start_i) begin
        mul_run_q <= 1'b1;
        mstep_q   <= '0;
      end else if (mul_run_q) begin
        mstep_q <= mstep_q + 2'd1;
        if (mstep_q == 2'd3) mul_run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      am_q  <= a_i[pewg_pkg::WIDE_W-1] ? -a_i : a_i;
      bm_q  <= b_i[pewg_pkg::WIDE_W-1] ? -b_i : b_i;
      neg_q <= a_i[pewg_pkg::WIDE_W-1] ^ b_i[pewg_pkg::WIDE_W-1];
      acc_q <= '0;
    end else if (acc_run_q) begin
      acc_q <= acc_q + shifted;
    end
    if (mul_run_q) begin
      prod_q   <= prod_d;
      pshift_q <= {1'b0, mstep_q[0]} + {1'b0, mstep_q[1]};
    end
    // Clip once the magnitude reaches 2^63 after rounding
    if (rnd_q) begin
      if (|rounded[ACC_W-1:pewg_pkg::WIDE_W+15]) begin
        res_q <= neg_q ? pewg_pkg::SAT_NEG : pewg_pkg::SAT_POS;
      end else begin
        res_q <= neg_q ? -mag_s : mag_s;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== design/pewg_datapath.sv =====
// Datapath: coefficient store, working registers, shared multiplier and output register.
module pewg_datapath #(
  parameter int unsigned POLY_ORDER = pewg_pkg::ORDER_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pewg_pkg::cmd_t                       cmd_i,
  output pewg_pkg::status_t                    status_o,
  input  logic [pewg_pkg::WORD_W-1:0]          in_data_i,
  input  logic                                 cfg_we_i,
  input  logic [pewg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pewg_pkg::WORD_W-1:0]          cfg_wdata_i,
  output logic [pewg_pkg::OUT_DATA_W-1:0]      out_data_o,
  output logic [pewg_pkg::TERM_W-1:0]          out_user_o,
  output logic                                 out_last_o
);

  localparam int unsigned ORD = pewg_pkg::clamp_order(POLY_ORDER);
  localparam logic [pewg_pkg::TERM_W-1:0] P_TOP = pewg_pkg::TERM_W'(ORD);
  localparam logic [pewg_pkg::TERM_W-1:0] S_TOP = pewg_pkg::TERM_W'(ORD - 1);

  logic [pewg_pkg::WORD_W-1:0]         coeff_q [4];
  logic [pewg_pkg::WORD_W-1:0]         slope_q [3];
  logic [pewg_pkg::WORD_W-1:0]         d_q;
  logic signed [pewg_pkg::WIDE_W-1:0]  p_q, dp_q, m_q, s_q, pw_q;
  logic [pewg_pkg::WORD_W-1:0]         out_poly_q, out_slope_q, out_pow_q;
  logic [pewg_pkg::TERM_W-1:0]         out_k_q;
  logic                                out_last_q;

  logic signed [pewg_pkg::WIDE_W-1:0]  cfg_val, op_a, op_b, op_c, mul_res, op_res;
  logic                                mul_done;
  logic [pewg_pkg::WORD_W-1:0]         slope_sel;

  assign cfg_val = pewg_pkg::sext32(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) coeff_q[i] <= '0;
      for (int i = 0; i < 3; i++) slope_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pewg_pkg::REG_COEFF_0: coeff_q[0] <= cfg_wdata_i;
        pewg_pkg::REG_COEFF_1: begin
          coeff_q[1] <= {1'b0, cfg_wdata_i[pewg_pkg::WORD_W-2:0]};
          slope_q[0] <= {1'b0, cfg_wdata_i[pewg_pkg::WORD_W-2:0]};
        end
        pewg_pkg::REG_COEFF_2: begin
          coeff_q[2] <= cfg_wdata_i;
          slope_q[1] <= pewg_pkg::sat32(cfg_val <<< 1);
        end
        pewg_pkg::REG_COEFF_3: begin
          coeff_q[3] <= cfg_wdata_i;
          slope_q[2] <= pewg_pkg::sat32((cfg_val <<< 1) + cfg_val);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.idx)
      2'd0:    slope_sel = slope_q[0];
      2'd1:    slope_sel = slope_q[1];
      2'd2:    slope_sel = slope_q[2];
      default: slope_sel = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.a_sel)
      pewg_pkg::A_P:  op_a = p_q;
      pewg_pkg::A_DP: op_a = dp_q;
      pewg_pkg::A_M:  op_a = m_q;
      pewg_pkg::A_PW: op_a = pw_q;
      default:        op_a = pewg_pkg::sext32(d_q);
    endcase
    case (cmd_i.b_sel)
      pewg_pkg::B_M:    op_b = m_q;
      pewg_pkg::B_HALF: op_b = pewg_pkg::Q_NEG_HALF;
      default:          op_b = pewg_pkg::sext32(d_q);
    endcase
    case (cmd_i.c_sel)
      pewg_pkg::C_COEFF: op_c = pewg_pkg::sext32(coeff_q[cmd_i.idx]);
      pewg_pkg::C_SLOPE: op_c = pewg_pkg::sext32(slope_sel);
      default:           op_c = '0;
    endcase
  end

  pewg_qmul u_qmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_op),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  assign op_res            = pewg_pkg::sadd(mul_res, op_c);
  assign status_o.mul_done = mul_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      d_q  <= in_data_i;
      p_q  <= pewg_pkg::sext32(coeff_q[P_TOP]);
      dp_q <= pewg_pkg::sext32(slope_q[S_TOP]);
      pw_q <= pewg_pkg::Q_ONE;
    end else if (mul_done) begin
      case (cmd_i.dst)
        pewg_pkg::DST_P:  p_q  <= op_res;
        pewg_pkg::DST_DP: dp_q <= op_res;
        pewg_pkg::DST_M:  m_q  <= op_res;
        pewg_pkg::DST_S:  s_q  <= op_res;
        default:          pw_q <= op_res;
      endcase
    end
    if (cmd_i.load_out) begin
      out_poly_q  <= pewg_pkg::sat32(p_q);
      out_slope_q <= pewg_pkg::sat32(s_q);
      out_pow_q   <= pewg_pkg::sat32(pw_q);
      out_k_q     <= cmd_i.idx;
      out_last_q  <= cmd_i.last;
    end
  end

  assign out_data_o = {out_pow_q, out_slope_q, out_poly_q};
  assign out_user_o = out_k_q;
  assign out_last_o = out_last_q;

endmodule

// ===== design/pewg_ctrl.sv =====
// Controller: sequences Horner steps, the d^3 scale, the slope product and the power beats.
module pewg_ctrl #(
  parameter int unsigned POLY_ORDER = pewg_pkg::ORDER_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pewg_pkg::status_t status_i,
  output pewg_pkg::cmd_t    cmd_o
);

  localparam int unsigned ORD = pewg_pkg::clamp_order(POLY_ORDER);
  localparam logic [pewg_pkg::TERM_W-1:0] K_LAST      = pewg_pkg::TERM_W'(ORD);
  localparam logic [pewg_pkg::TERM_W-1:0] K_P_START   = pewg_pkg::TERM_W'(ORD - 1);
  localparam logic [pewg_pkg::TERM_W-1:0] K_DP_START  = pewg_pkg::TERM_W'((ORD >= 2) ? ORD - 2 : 0);
  localparam logic                        HAS_DP      = (ORD >= 2);
  localparam logic [pewg_pkg::TERM_W-1:0] K_CUBE_LAST = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  typedef enum logic [4:0] {
    PH_P     = 5'b00001,
    PH_DP    = 5'b00010,
    PH_CUBE  = 5'b00100,
    PH_SLOPE = 5'b01000,
    PH_POWER = 5'b10000
  } phase_e;

  state_e                      state_q, state_d;
  phase_e                      phase_q, phase_d;
  logic [pewg_pkg::TERM_W-1:0] k_q, k_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.idx      = k_q;
    cmd_o.last     = (k_q == K_LAST);
    cmd_o.load_in  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.start_op = (state_q == S_ISSUE);
    cmd_o.load_out = (state_q == S_EMIT) && out_free;
    unique case (phase_q)
      PH_P: begin
        cmd_o.a_sel = pewg_pkg::A_P;
        cmd_o.b_sel = pewg_pkg::B_D;
        cmd_o.c_sel = pewg_pkg::C_COEFF;
        cmd_o.dst   = pewg_pkg::DST_P;
      end
      PH_DP: begin
        cmd_o.a_sel = pewg_pkg::A_DP;
        cmd_o.b_sel = pewg_pkg::B_D;
        cmd_o.c_sel = pewg_pkg::C_SLOPE;
        cmd_o.dst   = pewg_pkg::DST_DP;
      end
      PH_CUBE: begin
        // d*d, then *d, then scale by -0.5
        cmd_o.a_sel = (k_q == 2'd0) ? pewg_pkg::A_D : pewg_pkg::A_M;
        cmd_o.b_sel = (k_q == K_CUBE_LAST) ? pewg_pkg::B_HALF : pewg_pkg::B_D;
        cmd_o.c_sel = pewg_pkg::C_ZERO;
        cmd_o.dst   = pewg_pkg::DST_M;
      end
      PH_SLOPE: begin
        cmd_o.a_sel = pewg_pkg::A_DP;
        cmd_o.b_sel = pewg_pkg::B_M;
        cmd_o.c_sel = pewg_pkg::C_ZERO;
        cmd_o.dst   = pewg_pkg::DST_S;
      end
      PH_POWER: begin
        cmd_o.a_sel = pewg_pkg::A_PW;
        cmd_o.b_sel = pewg_pkg::B_D;
        cmd_o.c_sel = pewg_pkg::C_ZERO;
        cmd_o.dst   = pewg_pkg::DST_PW;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_ISSUE;
          phase_d = PH_P;
          k_d     = K_P_START;
        end
      end
      S_ISSUE: state_d = S_WAIT;
      S_WAIT: begin
        if (status_i.mul_done) begin
          state_d = S_ISSUE;
          unique case (phase_q)
            PH_P: begin
              if (k_q != 2'd0) begin
                k_d = k_q - 2'd1;
              end else if (HAS_DP) begin
                phase_d = PH_DP;
                k_d     = K_DP_START;
              end else begin
                phase_d = PH_CUBE;
                k_d     = '0;
              end
            end
            PH_DP: begin
              if (k_q != 2'd0) begin
                k_d = k_q - 2'd1;
              end else begin
                phase_d = PH_CUBE;
                k_d     = '0;
              end
            end
            PH_CUBE: begin
              if (k_q == K_CUBE_LAST) phase_d = PH_SLOPE;
              else k_d = k_q + 2'd1;
            end
            PH_SLOPE: begin
              state_d = S_EMIT;
              k_d     = '0;
            end
            default: state_d = S_EMIT;
          endcase
        end
      end
      S_EMIT: begin
        // Hand the beat to the output register once it is free
        if (out_free) begin
          out_valid_d = 1'b1;
          if (k_q == K_LAST) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_ISSUE;
            phase_d = PH_POWER;
            k_d     = k_q + 2'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_P;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/pewg_checker.sv =====
// Port-level checker for the polynomial evaluator, bound to the top level.
module pewg_checker #(
  parameter int unsigned POLY_ORDER = pewg_pkg::ORDER_DEFAULT
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pewg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [pewg_pkg::TERM_W-1:0]     m_axis_tuser,
  input logic                            m_axis_tlast
);

  localparam int unsigned ORD = pewg_pkg::clamp_order(POLY_ORDER);
  localparam logic [pewg_pkg::TERM_W-1:0] K_LAST = pewg_pkg::TERM_W'(ORD);

  // tlast marks exactly the highest power
  a_last_matches_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == K_LAST)))
    else $error("tlast does not match the final term index");

  // No new item while a run still has beats to deliver
  a_no_accept_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("input ready while a run is still in progress");

  // One item at a time: ready drops right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("stalled output beat changed");

endmodule

bind polynomial_eval_with_gradients pewg_checker #(
  .POLY_ORDER (POLY_ORDER)
) u_pewg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== bench/pewg_scoreboard.sv =====
`timescale 1ns / 1ps
// Scoreboard for the polynomial evaluator: Q16.16 term predictor and queue of expected term beats.
package pewg_tb_pkg;
  import pewg_pkg::*;

  typedef struct {
    logic [WORD_W-1:0] poly_value;
    logic [WORD_W-1:0] inv_dsq_slope;
    logic [TERM_W-1:0] term_index;
    logic [WORD_W-1:0] width_power;
    logic              last_term;
  } term_beat_t;

  class poly_scoreboard;
    int unsigned order;
    logic signed [WIDE_W-1:0] coeff [4];
    logic signed [WIDE_W-1:0] slope [3];
    term_beat_t pending_terms [$];
    int unsigned errors;
    int unsigned widths_in;
    int unsigned beats_out;

    function new(int unsigned poly_order);
      order = poly_order < ORDER_MIN ? ORDER_MIN :
              (poly_order > ORDER_MAX ? ORDER_MAX : poly_order);
      foreach (coeff[i]) coeff[i] = '0;
      foreach (slope[i]) slope[i] = '0;
      errors    = 0;
      widths_in = 0;
      beats_out = 0;
    endfunction

    // Exact product, round half away from zero, keep within +-(2^63-1).
    function logic signed [WIDE_W-1:0] q_mul(logic signed [WIDE_W-1:0] a,
                                             logic signed [WIDE_W-1:0] b);
      logic [WIDE_W-1:0] am, bm;
      logic [2*WIDE_W-1:0] prod;
      logic signed [WIDE_W-1:0] mag_q;
      logic neg;
      neg  = a[WIDE_W-1] ^ b[WIDE_W-1];
      am   = a[WIDE_W-1] ? -a : a;
      bm   = b[WIDE_W-1] ? -b : b;
      prod = {64'd0, am} * {64'd0, bm};
      prod = prod + 128'd32768;
      if (prod[127:79] != '0) return neg ? -SAT_POS : SAT_POS;
      mag_q = prod[79:16];
      return neg ? -mag_q : mag_q;
    endfunction

    function logic signed [WIDE_W-1:0] s_add(logic signed [WIDE_W-1:0] a,
                                             logic signed [WIDE_W-1:0] b);
      logic signed [WIDE_W:0] sum, lim;
      lim = {1'b0, SAT_POS};
      sum = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
      if (sum > lim) return SAT_POS;
      if (sum < -lim) return -SAT_POS;
      return sum[WIDE_W-1:0];
    endfunction

    function logic [WORD_W-1:0] clip32(logic signed [WIDE_W-1:0] v);
      if (v > W32_MAX) return 32'h7FFF_FFFF;
      if (v < W32_MIN) return 32'h8000_0000;
      return v[WORD_W-1:0];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
      logic signed [WIDE_W-1:0] mult;
      logic [WORD_W-1:0] clipped;
      if (idx > REG_COEFF_3) return;
      // coeff_1 is 31 bits wide: the sign bit of the write is dropped
      if (idx == REG_COEFF_1) coeff[idx] = {33'd0, val[30:0]};
      else coeff[idx] = {{32{val[31]}}, val};
      if (idx != REG_COEFF_0) begin
        mult    = idx;
        clipped = clip32(mult * coeff[idx]);
        slope[idx-1] = {{32{clipped[31]}}, clipped};
      end
    endfunction

    function void note_width(logic [WORD_W-1:0] din);
      logic signed [WIDE_W-1:0] d, p, dp, m, pw;
      logic [WORD_W-1:0] pv, sv;
      term_beat_t t;
      d = {{32{din[31]}}, din};
      p = coeff[order];
      for (int k = int'(order) - 1; k >= 0; k--) p = s_add(q_mul(p, d), coeff[k]);
      dp = slope[order-1];
      for (int k = int'(order) - 2; k >= 0; k--) dp = s_add(q_mul(dp, d), slope[k]);
      m  = q_mul(q_mul(q_mul(d, d), d), Q_NEG_HALF);
      sv = clip32(q_mul(dp, m));
      pv = clip32(p);
      pw = Q_ONE;
      for (int k = 0; k <= int'(order); k++) begin
        if (k > 0) pw = q_mul(pw, d);
        t.poly_value    = pv;
        t.inv_dsq_slope = sv;
        t.term_index    = 2'(k);
        t.width_power   = clip32(pw);
        t.last_term     = (k == int'(order));
        pending_terms.push_back(t);
      end
      widths_in++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("ERROR: %s", msg);
    endtask

    task check_beat(logic [OUT_DATA_W-1:0] tdata, logic [TERM_W-1:0] tuser, logic tlast);
      term_beat_t want;
      beats_out++;
      if (pending_terms.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing expected, tdata=%h", beats_out, tdata));
        return;
      end
      want = pending_terms.pop_front();
      if (tdata[31:0] !== want.poly_value)
        report($sformatf("beat %0d poly_value %h, want %h", beats_out, tdata[31:0],
                         want.poly_value));
      if (tdata[63:32] !== want.inv_dsq_slope)
        report($sformatf("beat %0d inv_dsq_slope %h, want %h", beats_out, tdata[63:32],
                         want.inv_dsq_slope));
      if (tdata[95:64] !== want.width_power)
        report($sformatf("beat %0d width_power %h, want %h", beats_out, tdata[95:64],
                         want.width_power));
      if (tuser !== want.term_index)
        report($sformatf("beat %0d term_index %0d, want %0d", beats_out, tuser,
                         want.term_index));
      if (tlast !== want.last_term)
        report($sformatf("beat %0d last_term %b, want %b", beats_out, tlast, want.last_term));
    endtask
  endclass

endpackage

// ===== bench/polynomial_eval_with_gradients_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the polynomial evaluator: corner and random widths over coefficient sets.
module polynomial_eval_with_gradients_tb;
  import pewg_pkg::*;
  import pewg_tb_pkg::*;

  localparam int unsigned POLY_ORDER    = ORDER_DEFAULT;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned TAIL_CYCLES   = 120;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 26;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [WORD_W-1:0]     cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [WORD_W-1:0]     s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [TERM_W-1:0]     m_axis_tuser;
  logic                  m_axis_tlast;

  poly_scoreboard sb = new(POLY_ORDER);
  bit             quiet = 1'b0;
  int unsigned    coeff_sets = 0;
  int unsigned    cycles = 0;

  polynomial_eval_with_gradients #(
    .POLY_ORDER(POLY_ORDER)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still expected", cycles,
               sb.pending_terms.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic set_coeffs(input logic [WORD_W-1:0] c0, input logic [WORD_W-1:0] c1,
                            input logic [WORD_W-1:0] c2, input logic [WORD_W-1:0] c3);
    write_reg(REG_COEFF_0, c0);
    write_reg(REG_COEFF_1, c1);
    write_reg(REG_COEFF_2, c2);
    write_reg(REG_COEFF_3, c3);
    // index past the last register: must leave every coefficient alone
    write_reg(REG_COEFF_3 + 3'($urandom_range(1, 4)), $urandom());
    cfg_we_i <= 1'b0;
    coeff_sets++;
  endtask

  task automatic send_width(input logic [WORD_W-1:0] d);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_width(d);
  endtask

  // Hold the input side until every expected beat has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_terms.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [WORD_W-1:0] pick_width();
    logic signed [WORD_W-1:0] r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r = 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      4, 5:       r = $urandom();
      6: begin
        case ($urandom_range(0, 6))
          0:       r = 32'h0000_0000;
          1:       r = 32'h0000_0001;
          2:       r = 32'hFFFF_FFFF;
          3:       r = 32'h7FFF_FFFF;
          4:       r = 32'h8000_0000;
          5:       r = 32'h0001_0000;
          default: r = 32'hFFFF_0000;
        endcase
      end
      7: begin
        r = $urandom();
        r = r >>> 7;
      end
      default: begin
        r = $urandom_range(0, 16'hFFFF);
        if ($urandom_range(0, 1) != 0) r = -r;
      end
    endcase
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] pick_coeff();
    logic [WORD_W-1:0] r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: r = 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      6, 7:             r = $urandom();
      8:                r = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default:          r = '0;
    endcase
    return r;
  endfunction

  initial begin : stimulus
    logic [WORD_W-1:0] corner_widths [14] = '{
      32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h0000_0001, 32'hFFFF_FFFF, 32'h0002_0000, 32'h0000_8000, 32'hFFFF_8000,
      32'h0100_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_4000
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // coefficients straight out of reset are all zero
    send_width(32'h0001_0000);
    send_width(32'hFFFF_0000);
    drain();

    // 1.0 + 2.0 d - 0.5 d^2 + 0.25 d^3 over the corner widths
    set_coeffs(32'h0001_0000, 32'h0002_0000, 32'hFFFF_8000, 32'h0000_4000);
    foreach (corner_widths[i]) send_width(corner_widths[i]);
    drain();

    // extremes; coeff_1 write carries a set sign bit that must be dropped
    set_coeffs(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_width(32'h7FFF_FFFF);
    send_width(32'h8000_0000);
    send_width(32'h0001_0000);
    send_width(32'h0000_0001);
    drain();

    // negative coeff_1 write lands as zero
    set_coeffs(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_width(32'hFFFF_FFFF);
    send_width(32'h0003_0000);
    send_width(32'hFFFD_0000);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      quiet = (ph == 2);
      set_coeffs(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_width(pick_width());
        if (ph == 3 && n == PHASE_ITEMS / 2) drain();
      end
      drain();
    end
    quiet = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending_terms.size() != 0)
      sb.report($sformatf("%0d expected beats never arrived", sb.pending_terms.size()));
    $display("Covered %0d widths, %0d term beats, %0d coefficient sets incl. extremes",
             sb.widths_in, sb.beats_out, coeff_sets);
    $display("Both sides stalled at random, with one stall-free phase and a mid-phase drain");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : sink
    int hold;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1 || rst_ni !== 1'b1);
      sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

endmodule
